[hw/rtl/mpa_pkg.sv]
package mpa_pkg;

  localparam int MAX_OUT_WIDTH = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int IDX_W         = 28;
  localparam int SLOT_W        = $clog2(MAX_OUT_WIDTH);
  localparam int COL_W         = 10;
  localparam int ROW_W         = 10;
  localparam int CHAN_W        = 8;
  localparam int WIN_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS,
    REG_IN_HEIGHT,
    REG_IN_WIDTH,
    REG_POOL_H,
    REG_POOL_W
  } cfg_reg_t;

  // clamped register values
  typedef struct packed {
    logic [8:0]  nc;
    logic [10:0] nh;
    logic [10:0] nw;
    logic [3:0]  ph;
    logic [3:0]  pw;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]              origin;
    logic                          seed;
    logic                          seg_end;
    logic                          emit;
    logic                          use_store;
    logic [SLOT_W-1:0]             slot;
    logic [IDX_W-1:0]              out_index;
    logic                          frame_end;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [IDX_W-1:0]              origin;
  } best_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [IDX_W-1:0]              origin_index;
    logic [IDX_W-1:0]              out_index;
    logic                          frame_end;
  } result_t;

  // col / pw for pw in 1..8, reciprocal multiply, exact for col < 1024
  function automatic logic [COL_W-1:0] div_pool(input logic [COL_W-1:0] col,
                                                input logic [3:0] pw);
    logic [23:0] p;
    logic [COL_W-1:0] q;
    p = '0;
    q = col;
    case (pw)
      4'd2: q = col >> 1;
      4'd3: begin
        p = 24'(col) * 24'd683;
        q = COL_W'(p >> 11);
      end
      4'd4: q = col >> 2;
      4'd5: begin
        p = 24'(col) * 24'd820;
        q = COL_W'(p >> 12);
      end
      4'd6: begin
        p = 24'(col) * 24'd683;
        q = COL_W'(p >> 12);
      end
      4'd7: begin
        p = 24'(col) * 24'd1171;
        q = COL_W'(p >> 13);
      end
      4'd8: q = col >> 3;
      default: q = col;
    endcase
    return q;
  endfunction

endpackage

[hw/rtl/mpa_front.sv]
module mpa_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mpa_pkg::cfg_t                        cfg,
  input  logic                                 push,
  input  logic signed [mpa_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                 q_full,
  output logic                                 q_push,
  output mpa_pkg::item_t                       q_item
);
  import mpa_pkg::*;

  logic [CHAN_W-1:0] chan_count, chan_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [COL_W-1:0]  col_count, col_count_next;
  logic [WIN_W-1:0]  win_row, win_row_next;
  logic [WIN_W-1:0]  win_col, win_col_next;
  logic [IDX_W-1:0]  in_index, in_index_next;
  logic [IDX_W-1:0]  out_count, out_count_next;

  logic col_end, row_end, chan_end, seg_end, band_end, last;

  assign col_end  = ({1'b0, col_count} + 11'd1) >= cfg.nw;
  assign row_end  = ({1'b0, row_count} + 11'd1) >= cfg.nh;
  assign chan_end = ({1'b0, chan_count} + 9'd1) >= cfg.nc;
  assign seg_end  = col_end || (({1'b0, win_col} + 4'd1) >= cfg.pw);
  assign band_end = row_end || (({1'b0, win_row} + 4'd1) >= cfg.ph);
  assign last     = col_end && row_end && chan_end;

  assign q_push = push && !q_full;

  always_comb begin
    q_item.sample    = sample;
    q_item.origin    = in_index;
    q_item.seed      = (win_col == '0);
    q_item.seg_end   = seg_end;
    q_item.emit      = seg_end && band_end;
    q_item.use_store = (win_row != '0);
    q_item.slot      = SLOT_W'(div_pool(col_count, cfg.pw));
    q_item.out_index = out_count;
    q_item.frame_end = last;
  end

  always_comb begin
    chan_count_next = chan_count;
    row_count_next  = row_count;
    col_count_next  = col_count;
    win_row_next    = win_row;
    win_col_next    = win_col;
    in_index_next   = in_index + IDX_W'(1);
    out_count_next  = (seg_end && band_end) ? out_count + IDX_W'(1) : out_count;
    if (col_end) begin
      col_count_next = '0;
      win_col_next   = '0;
      if (row_end) begin
        row_count_next = '0;
        win_row_next   = '0;
        if (chan_end) begin
          chan_count_next = '0;
          in_index_next   = '0;
          out_count_next  = '0;
        end else begin
          chan_count_next = chan_count + CHAN_W'(1);
        end
      end else begin
        row_count_next = row_count + ROW_W'(1);
        win_row_next   = band_end ? '0 : win_row + WIN_W'(1);
      end
    end else begin
      col_count_next = col_count + COL_W'(1);
      win_col_next   = seg_end ? '0 : win_col + WIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= '0;
      row_count  <= '0;
      col_count  <= '0;
      win_row    <= '0;
      win_col    <= '0;
      in_index   <= '0;
      out_count  <= '0;
    end else if (q_push) begin
      chan_count <= chan_count_next;
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      win_row    <= win_row_next;
      win_col    <= win_col_next;
      in_index   <= in_index_next;
      out_count  <= out_count_next;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_item.frame_end) |=> (in_index == '0 && out_count == '0 && col_count == '0))
    else $error("counters not cleared after last beat of frame");

  a_out_step: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_item.emit && !q_item.frame_end) |=>
      (out_count == $past(q_item.out_index) + IDX_W'(1)))
    else $error("output index did not step by one");

endmodule

[hw/rtl/mpa_queue.sv]
module mpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpa_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output mpa_pkg::item_t rdata,
  output logic           empty
);
  import mpa_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);

  item_t             slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push, do_pop;

  assign full    = (count == (PTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

[hw/rtl/mpa_back.sv]
module mpa_back (
  input  logic                                clk,
  input  logic                                rst,
  input  mpa_pkg::item_t                      q_item,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [mpa_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [mpa_pkg::IDX_W-1:0]           origin_index,
  output logic [mpa_pkg::IDX_W-1:0]           out_index,
  output logic                                frame_end
);
  import mpa_pkg::*;

  localparam int ODEPTH = 2;
  localparam int OPTR_W = $clog2(ODEPTH);

  // row band store, one entry per output column
  best_t store [MAX_OUT_WIDTH];
  best_t rd_q;
  logic  store_we;
  best_t store_wdata;

  logic signed [SAMPLE_BITS-1:0] run_max;
  logic [IDX_W-1:0]              run_origin;

  logic  s2_valid;
  item_t s2;

  logic  advance, out_full, out_push, out_pop, take_store;
  best_t best;

  result_t            oq [ODEPTH];
  logic [OPTR_W-1:0]  owr_ptr, ord_ptr;
  logic [OPTR_W:0]    ocount;
  result_t            head;

  assign out_full = (ocount == (OPTR_W+1)'(ODEPTH));
  assign advance  = !(s2_valid && s2.emit && out_full);
  assign q_pop    = advance && !q_empty;

  assign take_store = s2.use_store && !(run_max > rd_q.max_value);
  assign best       = take_store ? rd_q : best_t'{max_value: run_max, origin: run_origin};

  assign store_we    = advance && s2_valid && s2.seg_end && !s2.emit;
  assign store_wdata = best;
  assign out_push    = advance && s2_valid && s2.emit;

  // stage 1: running max of the window segment, store read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_item.seed || (q_item.sample > run_max)) begin
        run_max    <= q_item.sample;
        run_origin <= q_item.origin;
      end
      if (store_we && (s2.slot == q_item.slot)) begin
        rd_q <= store_wdata;
      end else begin
        rd_q <= store[q_item.slot];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[s2.slot] <= store_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2 <= q_item;
    end
  end

  // result queue
  assign empty        = (ocount == '0);
  assign out_pop      = pop && !empty;
  assign head         = oq[ord_ptr];
  assign max_value    = head.max_value;
  assign origin_index = head.origin_index;
  assign out_index    = head.out_index;
  assign frame_end    = head.frame_end;

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[owr_ptr] <= '{max_value: best.max_value, origin_index: best.origin,
                      out_index: s2.out_index, frame_end: s2.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (out_push) begin
        owr_ptr <= owr_ptr + OPTR_W'(1);
      end
      if (out_pop) begin
        ord_ptr <= ord_ptr + OPTR_W'(1);
      end
      ocount <= ocount + (OPTR_W+1)'(out_push) - (OPTR_W+1)'(out_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !advance) |=> (s2_valid && $stable(s2)))
    else $error("stage 2 beat lost during stall");

  a_we_or_emit: assert property (@(posedge clk) disable iff (rst)
    !(store_we && out_push))
    else $error("store write and result in same beat");

endmodule

[hw/rtl/max_pool_with_argmax.sv]
// 2-D max pooling with arg-max over a raster stream (channel, row, column).
// One sample is taken every clock while the internal four-entry queue has
// room; the sample closing a window passes from that queue through the
// stage 1 registers into the two-entry result queue, waiting only while the
// result side stalls, and sustained rate is one sample per cycle unless the
// result side holds pop low. Windows are pool_h x pool_w, non-overlapping,
// partial at the image edge; ties keep the earlier sample. origin_index is
// the flat input index of the winner, out_index the flat output index,
// frame_end marks the last result of the tensor. Register writes take effect
// at once and should be made while no beat is in flight; zero acts as 1,
// oversize values saturate (channels use data bits 8:0, pool sizes 3:0). Row
// band partials live in a 1024-entry store with one read and one write port.
module max_pool_with_argmax (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mpa_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [mpa_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [mpa_pkg::IDX_W-1:0]             origin_index,
  output logic [mpa_pkg::IDX_W-1:0]             out_index,
  output logic                                  frame_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mpa_pkg::*;

  cfg_t  cfg;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{nc: 9'd1, nh: 11'd1, nw: 11'd1, ph: 4'd2, pw: 4'd2};
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNELS: begin
          if (cfg_data[8:0] == '0) cfg.nc <= 9'd1;
          else if (cfg_data[8:0] > 9'd256) cfg.nc <= 9'd256;
          else cfg.nc <= cfg_data[8:0];
        end
        REG_IN_HEIGHT: begin
          if (cfg_data == '0) cfg.nh <= 11'd1;
          else if (cfg_data > 11'd1024) cfg.nh <= 11'd1024;
          else cfg.nh <= cfg_data;
        end
        REG_IN_WIDTH: begin
          if (cfg_data == '0) cfg.nw <= 11'd1;
          else if (cfg_data > 11'd1024) cfg.nw <= 11'd1024;
          else cfg.nw <= cfg_data;
        end
        REG_POOL_H: begin
          if (cfg_data[3:0] == '0) cfg.ph <= 4'd1;
          else if (cfg_data[3:0] > 4'd8) cfg.ph <= 4'd8;
          else cfg.ph <= cfg_data[3:0];
        end
        REG_POOL_W: begin
          if (cfg_data[3:0] == '0) cfg.pw <= 4'd1;
          else if (cfg_data[3:0] > 4'd8) cfg.pw <= 4'd8;
          else cfg.pw <= cfg_data[3:0];
        end
        default: ;
      endcase
    end
  end

  mpa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .sample (sample),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wdata)
  );

  mpa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .max_value    (max_value),
    .origin_index (origin_index),
    .out_index    (out_index),
    .frame_end    (frame_end)
  );

endmodule

[bench/tb_max_pool_with_argmax.sv]
module tb_max_pool_with_argmax;
  timeunit 1ns;
  timeprecision 1ps;

  import mpa_pkg::*;

  localparam int unsigned LIMIT = 600000;
  localparam int unsigned SETTLE = 10;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic empty;
  logic pop;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [IDX_W-1:0] origin_index;
  logic [IDX_W-1:0] out_index;
  logic frame_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  max_pool_with_argmax uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(sample),
    .empty(empty),
    .pop(pop),
    .max_value(max_value),
    .origin_index(origin_index),
    .out_index(out_index),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // pooling predictor: raw registers, position counters, row band partials
  int unsigned reg_channels = 1;
  int unsigned reg_in_height = 1;
  int unsigned reg_in_width = 1;
  int unsigned reg_pool_h = 2;
  int unsigned reg_pool_w = 2;
  int unsigned chan_pos = 0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  int unsigned win_r = 0;
  int unsigned win_c = 0;
  logic [IDX_W-1:0] in_idx = '0;
  logic [IDX_W-1:0] out_idx = '0;
  logic signed [SAMPLE_BITS-1:0] run_max = '0;
  logic [IDX_W-1:0] run_origin = '0;
  logic signed [SAMPLE_BITS-1:0] band_max [MAX_OUT_WIDTH];
  logic [IDX_W-1:0] band_origin [MAX_OUT_WIDTH];

  result_t pooled_q [$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pooled_q.size());
      $display("tb_max_pool_with_argmax NOT OK");
      $finish;
    end
  end

  function automatic int unsigned lim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic bit pool_step(input logic signed [SAMPLE_BITS-1:0] x, output result_t r);
    int unsigned nc, nh, nw, ph, pw, slot;
    bit col_end, row_end, chan_end, seg_end, band_end, emit;
    logic signed [SAMPLE_BITS-1:0] bv;
    logic [IDX_W-1:0] bo;
    nc = lim(reg_channels, 256);
    nh = lim(reg_in_height, 1024);
    nw = lim(reg_in_width, 1024);
    ph = lim(reg_pool_h, 8);
    pw = lim(reg_pool_w, 8);
    slot = (col_pos / pw) % MAX_OUT_WIDTH;
    col_end = col_pos + 1 >= nw;
    row_end = row_pos + 1 >= nh;
    chan_end = chan_pos + 1 >= nc;
    seg_end = col_end || (win_c + 1 >= pw);
    band_end = row_end || (win_r + 1 >= ph);
    emit = 1'b0;
    r = '0;
    // first sample of a window seeds it; ties keep the earlier one
    if (win_c == 0 || x > run_max) begin
      run_max = x;
      run_origin = in_idx;
    end
    if (seg_end) begin
      bv = run_max;
      bo = run_origin;
      if (win_r != 0 && !(run_max > band_max[slot])) begin
        bv = band_max[slot];
        bo = band_origin[slot];
      end
      if (band_end) begin
        r.max_value = bv;
        r.origin_index = bo;
        r.out_index = out_idx;
        r.frame_end = col_end && row_end && chan_end;
        out_idx = out_idx + 1'b1;
        emit = 1'b1;
      end else begin
        band_max[slot] = bv;
        band_origin[slot] = bo;
      end
    end
    in_idx = in_idx + 1'b1;
    if (col_end) begin
      col_pos = 0;
      win_c = 0;
      if (row_end) begin
        row_pos = 0;
        win_r = 0;
        if (chan_end) begin
          chan_pos = 0;
          in_idx = '0;
          out_idx = '0;
        end else begin
          chan_pos++;
        end
      end else begin
        row_pos++;
        win_r = band_end ? 0 : win_r + 1;
      end
    end else begin
      col_pos++;
      win_c = seg_end ? 0 : win_c + 1;
    end
    return emit;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return $signed(16'($urandom_range(3))) - 16'sd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned rand_dim(input int unsigned hi);
    if ($urandom_range(99) < 8) return 0;
    return $urandom_range(hi, 1);
  endfunction

  function automatic int unsigned rand_pool();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(15, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  task automatic report_mismatch(input string fld, input longint e, input longint a);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0d got %0d", $time, fld, e, a);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (pooled_q.size() == 0) begin
        report_mismatch("unexpected beat, max_value", 0, max_value);
      end else begin
        want = pooled_q.pop_front();
        if (max_value !== want.max_value)
          report_mismatch("max_value", want.max_value, max_value);
        if (origin_index !== want.origin_index)
          report_mismatch("origin_index", want.origin_index, origin_index);
        if (out_index !== want.out_index)
          report_mismatch("out_index", want.out_index, out_index);
        if (frame_end !== want.frame_end)
          report_mismatch("frame_end", want.frame_end, frame_end);
      end
    end
  end

  // result side: random pop, or a held-off stretch on request
  initial begin
    int unsigned n;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles != 0) begin
        n = stall_cycles;
        stall_cycles = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    result_t pooled;
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    do begin
      @(posedge clk);
    end while (full);
    items_sent++;
    if (pool_step(s, pooled)) pooled_q.push_back(pooled);
  endtask

  // samples until the predictor is back at the start of a tensor
  task automatic send_frame();
    do begin
      send_sample(rand_sample());
    end while (chan_pos != 0 || row_pos != 0 || col_pos != 0);
    frames_done++;
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] d;
    d = val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHANNELS: reg_channels = d[8:0];
      REG_IN_HEIGHT: reg_in_height = d;
      REG_IN_WIDTH: reg_in_width = d;
      REG_POOL_H: reg_pool_h = d[3:0];
      REG_POOL_W: reg_pool_w = d[3:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input int unsigned c, input int unsigned h, input int unsigned w,
                           input int unsigned ph, input int unsigned pw);
    wait_drain();
    write_reg(REG_CHANNELS, c);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_POOL_H, ph);
    write_reg(REG_POOL_W, pw);
  endtask

  // reset shape is a single sample per tensor
  task automatic test_reset_defaults();
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
  endtask

  task automatic test_seed_and_ties();
    logic signed [SAMPLE_BITS-1:0] pix [15];
    pix = '{-16'sd5, -16'sd5, 16'sd100, 16'sd7, 16'sh8000,
            -16'sd5, -16'sd7, 16'sd100, 16'sd100, -16'sd32767,
            16'sh7FFF, 16'sh7FFF, -16'sd1, -16'sd2, 16'sd0};
    set_shape(1, 3, 5, 2, 2);
    foreach (pix[i]) send_sample(pix[i]);
  endtask

  // zero acts as 1, oversize saturates, and safe writes land mid-tensor
  task automatic test_register_limits();
    set_shape(0, 0, 0, 0, 0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    set_shape(11'h7FF, 11'h7FF, 2, 15, 11'h7FF);
    repeat (24) send_sample(rand_sample());
    wait_drain();
    write_reg(REG_IN_HEIGHT, 3);
    write_reg(REG_POOL_H, 2);
    write_reg(REG_CHANNELS, 1);
    send_frame();
  endtask

  task automatic test_channel_sweep();
    set_shape(256, 1, 1, 1, 1);
    send_frame();
  endtask

  // one full-width row: column index runs over the whole range
  task automatic test_wide_rows();
    set_shape(1, 1, 1024, 1, 5);
    send_frame();
  endtask

  task automatic test_backpressure();
    int unsigned keep;
    keep = snd_idle_pct;
    set_shape(2, 4, 16, 1, 1);
    snd_idle_pct = 0;
    stall_cycles = 300;
    send_frame();
    snd_idle_pct = keep;
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned goal;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      set_shape(rand_dim(3), rand_dim(6),
                ($urandom_range(9) == 0) ? rand_dim(48) : rand_dim(16),
                rand_pool(), rand_pool());
      send_frame();
    end
  endtask

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CHANNELS;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    snd_idle_pct = 29;
    rcv_idle_pct = 52;
    test_reset_defaults();
    test_seed_and_ties();
    test_register_limits();
    test_channel_sweep();
    test_random_frames(90);

    snd_idle_pct = 52;
    rcv_idle_pct = 29;
    test_wide_rows();
    test_random_frames(90);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random_frames(90);

    wait_drain();
    $display("pooled %0d samples over %0d tensors, %0d result beats checked, %0d errors",
             items_sent, frames_done, results_checked, errors);
    $display("covered register limits, mid-tensor writes, ties, a full-width row and a long stall");
    if (errors == 0) begin
      $display("tb_max_pool_with_argmax OK");
    end else begin
      $display("tb_max_pool_with_argmax NOT OK");
    end
    $finish;
  end

endmodule
